FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the dilation block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a in a cycle requires condition c in the same cycle.
`define BD5_ASSERT_NOW(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
		else $error("bd5 check failed");

// Condition a in a cycle requires condition c in the following cycle.
`define BD5_ASSERT_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
		else $error("bd5 check failed");

`endif

FILE: src/bd5_pkg.sv
// Package of the 5x5 binary dilation block: widths, defaults, register codes
// and small helper functions. No dependencies.
`default_nettype none

package bd5_pkg;

	localparam int ROW_WIDTH_DEF   = 16;
	localparam int KERNEL_SIZE_DEF = 5;
	localparam int MAX_ROWS_DEF    = 1024;

	localparam int PIX_W    = 16;
	localparam int IDX_W    = 10;
	localparam int MASK_W   = 25;
	localparam int ANCHOR_W = 3;
	localparam int AWID_W   = 5;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic [MASK_W-1:0]   MASK_RST   = 25'h1FF_FFFF;
	localparam logic [ANCHOR_W-1:0] ANCHOR_RST = 3'd2;
	localparam logic [AWID_W-1:0]   AWID_RST   = 5'd16;

	typedef enum logic [1:0] {
		REG_KERNEL_MASK  = 2'd0,
		REG_ANCHOR_ROW   = 2'd1,
		REG_ANCHOR_COL   = 2'd2,
		REG_ACTIVE_WIDTH = 2'd3
	} reg_idx_t;

	// Anchor values past the last element row or column act as the last one.
	function automatic logic [ANCHOR_W-1:0] clamp_anchor(
		input logic [ANCHOR_W-1:0] a,
		input logic [ANCHOR_W-1:0] last
	);
		return (a > last) ? last : a;
	endfunction

endpackage

`default_nettype wire

FILE: src/bd5_if.sv
// Valid/ready channel interfaces for the dilation block: input rows and
// result rows. Depends on bd5_pkg.
`default_nettype none

interface bd5_row_if;
	logic                       valid;
	logic                       ready;
	logic [bd5_pkg::PIX_W-1:0] row_pixels;
	logic                       last_row;

	modport source (output valid, output row_pixels, output last_row, input ready);
	modport sink   (input valid, input row_pixels, input last_row, output ready);
endinterface

interface bd5_res_if;
	logic                       valid;
	logic                       ready;
	logic [bd5_pkg::PIX_W-1:0] dilated_pixels;
	logic [bd5_pkg::IDX_W-1:0] out_row_index;
	logic                       frame_done;

	modport source (output valid, output dilated_pixels, output out_row_index,
		output frame_done, input ready);
	modport sink   (input valid, input dilated_pixels, input out_row_index,
		input frame_done, output ready);
endinterface

`default_nettype wire

FILE: src/bd5_dilate.sv
// Combinational dilation of one window of stored rows into one output row.
// Depends on bd5_pkg.
`default_nettype none

module bd5_dilate #(
	parameter int ROW_WIDTH   = bd5_pkg::ROW_WIDTH_DEF,
	parameter int KERNEL_SIZE = bd5_pkg::KERNEL_SIZE_DEF
) (
	input  wire logic [KERNEL_SIZE-1:0][ROW_WIDTH-1:0] win,
	input  wire logic [bd5_pkg::MASK_W-1:0]            kernel_mask,
	input  wire logic [bd5_pkg::ANCHOR_W-1:0]          anchor_col,
	input  wire logic [ROW_WIDTH-1:0]                  width_mask,
	output      logic [ROW_WIDTH-1:0]                  dilated
);

	// Window entry 0 holds the newest row, which lines up with the last
	// element row; every set element contributes a column-shifted copy.
	always_comb begin
		logic [ROW_WIDTH-1:0] acc;
		logic [ROW_WIDTH-1:0] src;
		acc = '0;
		for (int ki = 0; ki < KERNEL_SIZE; ki++) begin
			src = win[KERNEL_SIZE-1-ki];
			for (int kj = 0; kj < KERNEL_SIZE; kj++) begin
				if (kernel_mask[ki*KERNEL_SIZE+kj]) begin
					if (kj >= int'(anchor_col))
						acc = acc | (src >> 3'(kj - int'(anchor_col)));
					else
						acc = acc | (src << 3'(int'(anchor_col) - kj));
				end
			end
		end
		dilated = acc & width_mask;
	end

endmodule

`default_nettype wire

FILE: src/binary_dilation_5x5.sv
// Streaming 5x5 binary dilation: configuration registers, row window and
// result register. Depends on bd5_pkg, bd5_if.sv and bd5_dilate.
//
// Usage. Image rows enter on row_ch, one transfer per row, bit j standing for
// column j; last_row marks the final row of a frame. Dilated rows leave on
// res_ch with their row number within the frame, and frame_done set on the
// last result of the frame. The structuring element mask, its anchor and the
// active width are written through the APB port (byte addresses 0, 4, 8, 12)
// while no frame is in flight; reads return the register values.
//
// Timing. A taken row loads the result it completes into the result register at
// the same clock edge, so it is offered on res_ch in the next cycle, and one row
// can be taken every cycle while res_ch does not stall and no flush runs. Early
// rows complete none. The last row completes up to 1 + (4 - anchor_row) results,
// anchor_row capped at 4, and row_ch.ready stays low for the (4 - anchor_row)
// flush steps, longer while the receiver stalls, as zero rows are shifted in.
//
// Reset clears the row window, the row counters and the result valid flag, and
// loads the register defaults (full mask, anchor at the center, 16 columns).
// When the receiver stalls, the result register holds its transfer and
// row_ch.ready drops, so nothing is lost or taken twice.
`default_nettype none

module binary_dilation_5x5 #(
	parameter int ROW_WIDTH   = bd5_pkg::ROW_WIDTH_DEF,
	parameter int KERNEL_SIZE = bd5_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_ROWS    = bd5_pkg::MAX_ROWS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	bd5_row_if.sink                              row_ch,
	bd5_res_if.source                            res_ch,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bd5_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [bd5_pkg::APB_DATA_W-1:0]  pwdata,
	output      logic [bd5_pkg::APB_DATA_W-1:0]  prdata,
	output      logic                            pready
);

	localparam int CW = $clog2(MAX_ROWS);          // row counter width
	localparam int SW = $clog2(KERNEL_SIZE + 1);   // saturating seen count
	localparam int IW = (CW > bd5_pkg::IDX_W) ? CW : bd5_pkg::IDX_W;
	localparam int MW = (ROW_WIDTH > bd5_pkg::PIX_W) ? ROW_WIDTH : bd5_pkg::PIX_W;
	localparam logic [bd5_pkg::ANCHOR_W-1:0] KLAST = bd5_pkg::ANCHOR_W'(KERNEL_SIZE - 1);

	// Configuration registers.
	logic [bd5_pkg::MASK_W-1:0]   kernel_mask_q;
	logic [bd5_pkg::ANCHOR_W-1:0] anchor_row_q;
	logic [bd5_pkg::ANCHOR_W-1:0] anchor_col_q;
	logic [bd5_pkg::AWID_W-1:0]   active_width_q;
	bd5_pkg::reg_idx_t            reg_idx;
	logic                         cfg_wr;

	// Row window and frame bookkeeping.
	logic [KERNEL_SIZE-1:0][ROW_WIDTH-1:0] win_q;
	logic [KERNEL_SIZE-1:0][ROW_WIDTH-1:0] win_n;
	logic [CW-1:0]                         rows_q;
	logic [CW-1:0]                         rows_n;
	logic [SW-1:0]                         seen_q;
	logic [SW-1:0]                         seen_n;
	logic                                  flush_q;
	logic [bd5_pkg::ANCHOR_W-1:0]          t_q;

	// Result register.
	logic                       res_valid_s1;
	logic [bd5_pkg::PIX_W-1:0]  res_pix_s1;
	logic [bd5_pkg::IDX_W-1:0]  res_idx_s1;
	logic                       res_done_s1;

	logic [bd5_pkg::ANCHOR_W-1:0] ar;
	logic [bd5_pkg::ANCHOR_W-1:0] ac;
	logic [bd5_pkg::ANCHOR_W-1:0] delay;
	logic [bd5_pkg::ANCHOR_W-1:0] tcur;
	logic [ROW_WIDTH-1:0]         wmask;
	logic [MW-1:0]                row_ext;
	logic [ROW_WIDTH-1:0]         new_row;
	logic [ROW_WIDTH-1:0]         dil_row;
	logic [MW-1:0]                dil_ext;
	logic                         load;
	logic                         take;
	logic                         flush_step;
	logic                         step;
	logic                         emit;
	logic                         done;
	logic                         frame_end;
	logic [CW:0]                  idx_sum;
	logic [CW-1:0]                idx_mod;
	logic [IW-1:0]                idx_ext;

	// ---------------- APB configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = bd5_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_mask_q  <= bd5_pkg::MASK_RST;
			anchor_row_q   <= bd5_pkg::ANCHOR_RST;
			anchor_col_q   <= bd5_pkg::ANCHOR_RST;
			active_width_q <= bd5_pkg::AWID_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				bd5_pkg::REG_KERNEL_MASK:  kernel_mask_q  <= pwdata[bd5_pkg::MASK_W-1:0];
				bd5_pkg::REG_ANCHOR_ROW:   anchor_row_q   <= pwdata[bd5_pkg::ANCHOR_W-1:0];
				bd5_pkg::REG_ANCHOR_COL:   anchor_col_q   <= pwdata[bd5_pkg::ANCHOR_W-1:0];
				bd5_pkg::REG_ACTIVE_WIDTH: active_width_q <= pwdata[bd5_pkg::AWID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bd5_pkg::REG_KERNEL_MASK:  prdata = bd5_pkg::APB_DATA_W'(kernel_mask_q);
			bd5_pkg::REG_ANCHOR_ROW:   prdata = bd5_pkg::APB_DATA_W'(anchor_row_q);
			bd5_pkg::REG_ANCHOR_COL:   prdata = bd5_pkg::APB_DATA_W'(anchor_col_q);
			bd5_pkg::REG_ACTIVE_WIDTH: prdata = bd5_pkg::APB_DATA_W'(active_width_q);
			default:                   prdata = '0;
		endcase
	end

	// ---------------- Derived settings ----------------
	assign ar    = bd5_pkg::clamp_anchor(anchor_row_q, KLAST);
	assign ac    = bd5_pkg::clamp_anchor(anchor_col_q, KLAST);
	// Number of rows below the anchor: how far results trail the input.
	assign delay = KLAST - ar;

	// Columns at or beyond the active width (capped at the row width) are off.
	always_comb begin
		for (int j = 0; j < ROW_WIDTH; j++)
			wmask[j] = (7'(active_width_q) > 7'(j));
	end

	// ---------------- Handshake ----------------
	// The result register can be loaded when it is empty or being drained.
	// During an end-of-frame flush no new row is taken.
	assign load         = !res_valid_s1 || res_ch.ready;
	assign row_ch.ready = !flush_q && load;
	assign take         = row_ch.valid && row_ch.ready;
	assign flush_step   = flush_q && load;
	assign step         = take || flush_step;

	// ---------------- Window update ----------------
	// A taken row is masked to the active width; a flush step shifts in a
	// zero row standing for the rows below the frame.
	assign row_ext = MW'(row_ch.row_pixels);
	assign new_row = take ? (row_ext[ROW_WIDTH-1:0] & wmask) : '0;

	always_comb begin
		win_n[0] = new_row;
		for (int k = 1; k < KERNEL_SIZE; k++)
			win_n[k] = win_q[k-1];
	end

	always_comb begin
		if (take) begin
			seen_n = (seen_q == SW'(KERNEL_SIZE)) ? seen_q : seen_q + 1'b1;
			rows_n = (rows_q == CW'(MAX_ROWS - 1)) ? '0 : rows_q + 1'b1;
			tcur   = '0;
		end else begin
			seen_n = seen_q;
			rows_n = rows_q;
			tcur   = t_q;
		end
	end

	// A result exists once the rows below its anchor row are present.
	assign emit = (4'(seen_n) + 4'(tcur)) > 4'(delay);

	// Row number of the result: rows counted so far less one, plus flush steps, less
	// the trailing distance, modulo the frame row limit.
	assign idx_sum = (CW+1)'(rows_n) + (CW+1)'(tcur) + (CW+1)'(MAX_ROWS)
		- (CW+1)'(1) - (CW+1)'(delay);
	assign idx_mod = (idx_sum >= (CW+1)'(MAX_ROWS)) ?
		CW'(idx_sum - (CW+1)'(MAX_ROWS)) : CW'(idx_sum);
	assign idx_ext = IW'(idx_mod);

	// The frame ends on the last row when no flush is needed, or on the final
	// flush step.
	assign frame_end = (take && row_ch.last_row && (delay == '0))
		|| (flush_step && (t_q == delay));
	assign done      = frame_end;

	bd5_dilate #(
		.ROW_WIDTH   (ROW_WIDTH),
		.KERNEL_SIZE (KERNEL_SIZE)
	) u_dilate (
		.win         (win_n),
		.kernel_mask (kernel_mask_q),
		.anchor_col  (ac),
		.width_mask  (wmask),
		.dilated     (dil_row)
	);

	assign dil_ext = MW'(dil_row);

	// ---------------- State registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			rows_q  <= '0;
			seen_q  <= '0;
			flush_q <= 1'b0;
			t_q     <= '0;
		end else if (step) begin
			if (frame_end) begin
				win_q   <= '0;
				rows_q  <= '0;
				seen_q  <= '0;
				flush_q <= 1'b0;
				t_q     <= '0;
			end else begin
				win_q  <= win_n;
				rows_q <= rows_n;
				seen_q <= seen_n;
				if (take && row_ch.last_row) begin
					flush_q <= 1'b1;
					t_q     <= bd5_pkg::ANCHOR_W'(1);
				end else if (flush_step) begin
					t_q <= t_q + 1'b1;
				end
			end
		end
	end

	// ---------------- Result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_s1 <= 1'b0;
		else if (load)
			res_valid_s1 <= step && emit;
	end

	always_ff @(posedge clk) begin
		if (load && step && emit) begin
			res_pix_s1  <= dil_ext[bd5_pkg::PIX_W-1:0];
			res_idx_s1  <= idx_ext[bd5_pkg::IDX_W-1:0];
			res_done_s1 <= done;
		end
	end

	assign res_ch.valid          = res_valid_s1;
	assign res_ch.dilated_pixels = res_pix_s1;
	assign res_ch.out_row_index  = res_idx_s1;
	assign res_ch.frame_done     = res_done_s1;

endmodule

`default_nettype wire

FILE: src/bd5_checker.sv
// Port-level checks for the dilation block and the bind that attaches them.
// Depends on assert_macros.svh and bd5_pkg.
`default_nettype none
`include "assert_macros.svh"

module bd5_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      row_valid,
	input wire logic                      row_ready,
	input wire logic                      row_last,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic [bd5_pkg::PIX_W-1:0] res_pixels,
	input wire logic [bd5_pkg::IDX_W-1:0] res_index
);

	// A stalled result stays offered.
	`BD5_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// A stalled result keeps its payload.
	`BD5_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready,
		$stable(res_pixels) && $stable(res_index))

	// No row is taken while the result register is full and stalled.
	`BD5_ASSERT_NOW(a_stall_blocks, clk, arst_n, res_valid && !res_ready, !row_ready)

	// The last row of a frame either completes a result at once or starts a
	// flush that holds the input off.
	`BD5_ASSERT_NEXT(a_last_emits, clk, arst_n, row_valid && row_ready && row_last,
		res_valid || !row_ready)

endmodule

bind binary_dilation_5x5 bd5_checker u_bd5_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.row_valid  (row_ch.valid),
	.row_ready  (row_ch.ready),
	.row_last   (row_ch.last_row),
	.res_valid  (res_ch.valid),
	.res_ready  (res_ch.ready),
	.res_pixels (res_ch.dilated_pixels),
	.res_index  (res_ch.out_row_index)
);

`default_nettype wire
